// ----- rtl/full_linear_convolution_top_defines.svh -----
// Assertion macros shared by the convolution checker.
`ifndef FULL_LINEAR_CONVOLUTION_TOP_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define FLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/flc_pkg.sv -----
// Shared types and constants of the full linear convolution block.
package flc_pkg;

  localparam int OUT_W        = 36;
  localparam int VALUE_W      = 16;
  localparam int IDX_W        = 4;
  localparam int TAP_CNT_W    = 5;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 5'd1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [IDX_W-1:0]          coef_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_sample;
    logic                    last_output;
  } out_item_t;

  typedef struct packed {
    logic             shift;
    logic             clear;
    logic             load;
    logic [IDX_W-1:0] load_idx;
  } cell_ctl_t;

endpackage

// ----- rtl/flc_cell.sv -----
// One tap cell: delay register, coefficient register and registered product.
module flc_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int IDX        = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  flc_pkg::cell_ctl_t                 ctl,
  input  logic                               in_use,
  input  logic signed [DATA_WIDTH-1:0]       load_value,
  input  logic signed [DATA_WIDTH-1:0]       x_in,
  output logic signed [DATA_WIDTH-1:0]       x_out,
  output logic signed [flc_pkg::OUT_W-1:0]   prod
);

  logic signed [DATA_WIDTH-1:0]   x_q;
  logic signed [DATA_WIDTH-1:0]   coef_q;
  logic signed [2*DATA_WIDTH-1:0] mult;
  logic                           idx_hit;

  assign idx_hit = (32'(ctl.load_idx) == 32'(IDX));
  assign mult    = coef_q * x_in;
  assign x_out   = x_q;

  // Hold the tap sample and its coefficient; clear the sample after a flush
  always_ff @(posedge clk) begin
    if (rst) begin
      x_q    <= '0;
      coef_q <= '0;
    end else begin
      if (ctl.load && idx_hit) begin
        coef_q <= load_value;
      end
      if (ctl.shift) begin
        x_q <= ctl.clear ? '0 : x_in;
      end
    end
  end

  // Register the product of the incoming sample; drop taps beyond the count
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      prod <= in_use ? flc_pkg::OUT_W'(mult) : '0;
    end
  end

endmodule

// ----- rtl/flc_add_tree.sv -----
// Registered binary adder tree with per-level valid and backpressure.
module flc_add_tree #(
  parameter int N = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_last,
  input  logic signed [flc_pkg::OUT_W-1:0] leaf [N],
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [flc_pkg::OUT_W-1:0] out_sum,
  output logic                             out_last
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 0;
  localparam int N2     = 1 << LEVELS;

  logic v   [0:LEVELS];
  logic lf  [0:LEVELS];
  logic rdy [1:LEVELS+1];

  assign v[0]         = in_valid;
  assign lf[0]        = in_last;
  assign rdy[LEVELS+1] = out_ready;
  assign in_ready     = rdy[1];

  generate
    if (LEVELS == 0) begin : g_flat
      assign out_valid = in_valid;
      assign out_last  = in_last;
      assign out_sum   = leaf[0];
    end else begin : g_tree
      logic signed [flc_pkg::OUT_W-1:0] leaf_pad [0:N2-1];
      logic signed [flc_pkg::OUT_W-1:0] node_q   [0:N2-1];

      // Pad unused leaves with zero
      always_comb begin
        for (int i = 0; i < N2; i++) begin
          if (i < N) begin
            leaf_pad[i] = leaf[i];
          end else begin
            leaf_pad[i] = '0;
          end
        end
      end

      // A level advances when it is empty or the next one takes its beat
      for (genvar s = 1; s <= LEVELS; s++) begin : g_ctl
        assign rdy[s] = !v[s] || rdy[s+1];

        always_ff @(posedge clk) begin
          if (rst) begin
            v[s] <= 1'b0;
          end else if (rdy[s]) begin
            v[s] <= v[s-1];
          end
        end

        always_ff @(posedge clk) begin
          if (rdy[s]) begin
            lf[s] <= lf[s-1];
          end
        end
      end

      // Add pairs level by level; node 1 is the root
      always_ff @(posedge clk) begin
        for (int s = 1; s <= LEVELS; s++) begin
          if (rdy[s]) begin
            for (int i = 0; i < (N2 >> s); i++) begin
              if (s == 1) begin
                node_q[(N2 >> s) + i] <= leaf_pad[2*i] + leaf_pad[2*i+1];
              end else begin
                node_q[(N2 >> s) + i] <= node_q[2*((N2 >> s) + i)]
                                       + node_q[2*((N2 >> s) + i) + 1];
              end
            end
          end
        end
      end

      assign out_valid = v[LEVELS];
      assign out_last  = lf[LEVELS];
      assign out_sum   = node_q[1];
    end
  endgenerate

endmodule

// ----- rtl/full_linear_convolution_top.sv -----
// Top level of the streaming full linear convolution (direct-form FIR).
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+-------------------------
//   in      | input     | in_valid / in_ready   | in_item_t
//   out     | output    | out_valid / out_ready | out_item_t
//   cfg     | input     | cfg_valid / cfg_ready | tap count, 5 bits
//
// One beat per cycle on the input while no flush or output stall holds it:
// each sample shifts the tap chain and its result leaves through the product
// register, then the adder tree levels. A last sample adds taps_eff-1 flush
// steps (zero shifts, in_ready low); coefficient loads give no result.
// Reset clears taps, coefficients and pipeline valids at once; no sweep.
// Output stalls back up through the tree; empty levels still take beats.
module full_linear_convolution_top #(
  parameter int MAX_TAPS   = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  flc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output flc_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [flc_pkg::TAP_CNT_W-1:0]       cfg_data
);

  localparam int TW = $clog2(MAX_TAPS + 1);

  logic [flc_pkg::TAP_CNT_W-1:0] tap_count;
  logic [TW-1:0]                 taps_eff;
  logic [MAX_TAPS-1:0]           tap_use;

  logic                          flushing;
  logic                          flushing_next;
  logic [TW-1:0]                 flush_cnt;
  logic [TW-1:0]                 flush_cnt_next;

  logic                          pv;
  logic                          pl;
  logic                          pr;
  logic                          tree_ready;

  logic                          in_acc;
  logic                          samp_acc;
  logic                          flush_step;
  logic                          item_last;
  logic                          taps_one;
  logic                          cnt_one;
  logic signed [DATA_WIDTH-1:0]  v_low;
  flc_pkg::cell_ctl_t            ctl;

  logic signed [DATA_WIDTH-1:0]     x_chain [MAX_TAPS];
  logic signed [flc_pkg::OUT_W-1:0] prod    [MAX_TAPS];
  logic signed [flc_pkg::OUT_W-1:0] sum;
  logic                             sum_last;

  // Tap count register; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= flc_pkg::TAP_CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tap_count <= cfg_data;
    end
  end

  // Clamp the tap count into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(tap_count);
    end
  end

  // Take the sample in its low DATA_WIDTH bits, or zero-extend it when DATA_WIDTH is wider
  generate
    if (DATA_WIDTH <= flc_pkg::VALUE_W) begin : g_vnarrow
      assign v_low = in_data.value[DATA_WIDTH-1:0];
    end else begin : g_vwide
      assign v_low = {{(DATA_WIDTH - flc_pkg::VALUE_W){1'b0}}, in_data.value};
    end
  endgenerate

  // Input handshake and flush sequencing
  assign pr         = !pv || tree_ready;
  assign in_ready   = !flushing && pr;
  assign in_acc     = in_valid && in_ready;
  assign samp_acc   = in_acc && (in_data.action == flc_pkg::ACT_SAMPLE);
  assign flush_step = flushing && pr;
  assign taps_one   = (taps_eff == TW'(1));
  assign cnt_one    = (flush_cnt == TW'(1));
  assign item_last  = flush_step ? cnt_one : (in_data.last_sample && taps_one);

  always_comb begin
    flushing_next  = flushing;
    flush_cnt_next = flush_cnt;
    if (flush_step) begin
      flush_cnt_next = flush_cnt - TW'(1);
      if (cnt_one) begin
        flushing_next = 1'b0;
      end
    end else if (samp_acc && in_data.last_sample && !taps_one) begin
      flushing_next  = 1'b1;
      flush_cnt_next = taps_eff - TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_cnt <= '0;
    end else begin
      flushing  <= flushing_next;
      flush_cnt <= flush_cnt_next;
    end
  end

  // Cell controls: shift on a sample or flush step, clear after the final one
  always_comb begin
    ctl.shift    = samp_acc || flush_step;
    ctl.clear    = (flush_step && cnt_one)
                || (samp_acc && in_data.last_sample && taps_one);
    ctl.load     = in_acc && (in_data.action == flc_pkg::ACT_LOAD);
    ctl.load_idx = in_data.coef_index;
  end

  assign x_chain[0] = flush_step ? '0 : v_low;

  // Product stage valid and last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (pr) begin
      pv <= ctl.shift;
    end
  end

  always_ff @(posedge clk) begin
    if (pr) begin
      pl <= item_last;
    end
  end

  // Chain of tap cells
  generate
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      assign tap_use[k] = (32'(taps_eff) > k);

      if (k < MAX_TAPS - 1) begin : g_mid
        flc_cell #(
          .DATA_WIDTH(DATA_WIDTH),
          .IDX       (k)
        ) u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .in_use    (tap_use[k]),
          .load_value(v_low),
          .x_in      (x_chain[k]),
          .x_out     (x_chain[k+1]),
          .prod      (prod[k])
        );
      end else begin : g_end
        flc_cell #(
          .DATA_WIDTH(DATA_WIDTH),
          .IDX       (k)
        ) u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .in_use    (tap_use[k]),
          .load_value(v_low),
          .x_in      (x_chain[k]),
          .x_out     (),
          .prod      (prod[k])
        );
      end
    end
  endgenerate

  // Sum the products
  flc_add_tree #(
    .N(MAX_TAPS)
  ) u_tree (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pv),
    .in_ready (tree_ready),
    .in_last  (pl),
    .leaf     (prod),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sum  (sum),
    .out_last (sum_last)
  );

  always_comb begin
    out_data.out_sample  = sum;
    out_data.last_output = sum_last;
  end

endmodule

// ----- rtl/flc_checker.sv -----
// Port-level checker for the convolution top level, bound to it below.
`include "full_linear_convolution_top_defines.svh"

module flc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input flc_pkg::in_item_t             in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input flc_pkg::out_item_t            out_data
);

  logic last_acc;
  logic out_stall;

  assign last_acc  = in_valid && in_ready && in_data.last_sample
                  && (in_data.action == flc_pkg::ACT_SAMPLE);
  assign out_stall = out_valid && !out_ready;

  // A stalled result beat holds
  `FLC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "out beat moved")

  // Nothing comes out right after reset
  `FLC_ASSERT_ALWAYS(a_rst_quiet, rst |=> !out_valid, "out_valid high after reset")

  // Input only backs off for a flush or an output stall
  `FLC_ASSERT(a_ready_drop, $fell(in_ready) |-> out_stall || $past(last_acc), "in_ready fell")

endmodule

bind full_linear_convolution_top flc_checker u_flc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ----- dv/full_linear_convolution_top_tb.sv -----
// Testbench for the streaming full linear convolution block: directed and random streams.
module full_linear_convolution_top_tb;

  localparam int NUM_TAPS    = 16;
  localparam int DRAIN_CYC   = 24;
  localparam int RAND_ITEMS  = 430;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  flc_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_ready;
  flc_pkg::out_item_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [flc_pkg::TAP_CNT_W-1:0] cfg_data;

  // Predicted block state
  logic signed [flc_pkg::VALUE_W-1:0] coef_mem [NUM_TAPS];
  logic signed [flc_pkg::VALUE_W-1:0] sample_hist [NUM_TAPS];
  logic [flc_pkg::TAP_CNT_W-1:0]      tap_setting;

  flc_pkg::out_item_t pending_outputs [$];
  flc_pkg::out_item_t want;

  int err_count;
  int items_sent;
  int beats_checked;
  int tap_writes;
  int flushes_seen;

  // Traffic shaping
  bit  tx_bursty;
  bit  rx_stalls;
  int  burst_left;
  logic [15:0] stall_pat;
  int  stall_pos;

  full_linear_convolution_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective tap count: zero acts as one, large values clamp
  function automatic int active_taps();
    if (tap_setting == '0) return 1;
    if (tap_setting > NUM_TAPS) return NUM_TAPS;
    return int'(tap_setting);
  endfunction

  // Exact FIR sum over the active taps, wrapped to the output width
  function automatic logic signed [flc_pkg::OUT_W-1:0] tap_sum(input int taps);
    logic signed [63:0] acc;
    acc = '0;
    for (int k = 0; k < taps; k++) begin
      acc = acc + 64'(coef_mem[k]) * 64'(sample_hist[k]);
    end
    return acc[flc_pkg::OUT_W-1:0];
  endfunction

  function automatic void shift_hist(input logic signed [flc_pkg::VALUE_W-1:0] x);
    for (int k = NUM_TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
    sample_hist[0] = x;
  endfunction

  // Update predicted state for one accepted beat and queue its outputs
  function automatic void convolve_item(input flc_pkg::in_item_t it);
    int                 taps;
    flc_pkg::out_item_t r;
    taps = active_taps();
    if (it.action == flc_pkg::ACT_LOAD) begin
      coef_mem[it.coef_index] = it.value;
      return;
    end
    shift_hist(it.value);
    r.out_sample  = tap_sum(taps);
    r.last_output = it.last_sample && (taps == 1);
    pending_outputs.push_back(r);
    if (it.last_sample) begin
      for (int t = 1; t < taps; t++) begin
        shift_hist('0);
        r.out_sample  = tap_sum(taps);
        r.last_output = (t == taps - 1);
        pending_outputs.push_back(r);
      end
      for (int k = 0; k < NUM_TAPS; k++) sample_hist[k] = '0;
      flushes_seen++;
    end
  endfunction

  function automatic flc_pkg::in_item_t mk_item(
    input logic                               act,
    input logic [flc_pkg::IDX_W-1:0]          idx,
    input logic signed [flc_pkg::VALUE_W-1:0] v,
    input logic                               lst
  );
    flc_pkg::in_item_t it;
    it.action      = act;
    it.coef_index  = idx;
    it.value       = v;
    it.last_sample = lst;
    return it;
  endfunction

  // Random value with extra weight on the corners
  function automatic logic signed [flc_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'shFFFF;
      default: return flc_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 50) $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // Send one beat; gaps come between bursts when the sender is bursty
  task automatic send_item(input flc_pkg::in_item_t it);
    int gap;
    if (tx_bursty && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    convolve_item(it);
    items_sent++;
  endtask

  // Drop valid, wait for every queued result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_taps(input logic [flc_pkg::TAP_CNT_W-1:0] n);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tap_setting = n;
    tap_writes++;
  endtask

  // Receiver stall pattern, walked bit by bit and refreshed when stall_pos wraps
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_pos <= 0;
      stall_pat <= 16'hFFFF;
    end else begin
      out_ready <= rx_stalls ? stall_pat[stall_pos] : 1'b1;
      if (stall_pos == 15) begin
        stall_pos <= 0;
        case ($urandom_range(0, 3))
          0: stall_pat <= 16'h00FF;
          1: stall_pat <= 16'hFFFF;
          default: stall_pat <= 16'($urandom) | 16'h0001;
        endcase
      end else begin
        stall_pos <= stall_pos + 1;
      end
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat out_sample=%0d last_output=%0b",
                                  out_data.out_sample, out_data.last_output));
      end else begin
        want = pending_outputs.pop_front();
        if (out_data.out_sample !== want.out_sample)
          report_mismatch($sformatf("beat %0d out_sample got %0d want %0d", beats_checked,
                                    out_data.out_sample, want.out_sample));
        if (out_data.last_output !== want.last_output)
          report_mismatch($sformatf("beat %0d last_output got %0b want %0b", beats_checked,
                                    out_data.last_output, want.last_output));
        beats_checked++;
      end
    end
  end

  // Zero kernel after reset, default single tap
  task automatic test_reset_state();
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh1234, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd15, 16'sh7FFF, 1'b1));
  endtask

  // Single tap: each sample is its own flush
  task automatic test_single_tap();
    send_item(mk_item(flc_pkg::ACT_LOAD, 4'd0, 16'sh7FFF, 1'b1));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh0064, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh8000, 1'b1));
  endtask

  // Full kernel with corner coefficients and samples
  task automatic test_full_kernel();
    write_taps(5'd16);
    send_item(mk_item(flc_pkg::ACT_LOAD, 4'd0, 16'sh8000, 1'b0));
    send_item(mk_item(flc_pkg::ACT_LOAD, 4'd15, 16'sh8000, 1'b0));
    send_item(mk_item(flc_pkg::ACT_LOAD, 4'd7, 16'sh7FFF, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh8000, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh8000, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh7FFF, 1'b1));
  endtask

  // Tap count zero and tap count above the maximum
  task automatic test_tap_clamp();
    write_taps(5'd0);
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh4000, 1'b1));
    write_taps(5'd31);
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'shC000, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh0001, 1'b1));
  endtask

  // Coefficient stored past the tap count stays unused
  task automatic test_unused_coef();
    write_taps(5'd4);
    send_item(mk_item(flc_pkg::ACT_LOAD, 4'd10, 16'sh7FFF, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh2000, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'shE000, 1'b1));
  endtask

  // Grow the tap count mid-stream; older samples are still held
  task automatic test_midstream_change();
    write_taps(5'd3);
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh1111, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh2222, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh3333, 1'b0));
    write_taps(5'd8);
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh4444, 1'b0));
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh5555, 1'b1));
  endtask

  // Random phases: kernel loads then sample streams, with noise and broken streams
  task automatic test_random_streams();
    int start;
    int taps;
    int nconv;
    int nload;
    int len;
    logic [flc_pkg::TAP_CNT_W-1:0] n;
    logic [flc_pkg::IDX_W-1:0]     idx;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: n = 5'd0;
        1: n = 5'd16;
        2: n = 5'($urandom_range(17, 31));
        3, 4, 5: n = 5'($urandom_range(1, 4));
        default: n = 5'($urandom_range(1, 16));
      endcase
      write_taps(n);
      tx_bursty  = ($urandom_range(0, 2) != 0);
      rx_stalls  = ($urandom_range(0, 2) != 0);
      burst_left = 0;
      taps  = active_taps();
      nconv = $urandom_range(1, 4);
      for (int c = 0; c < nconv; c++) begin
        nload = $urandom_range(0, taps + 1);
        for (int j = 0; j < nload; j++) begin
          if ($urandom_range(0, 4) == 0) idx = flc_pkg::IDX_W'($urandom);
          else idx = flc_pkg::IDX_W'($urandom_range(0, taps - 1));
          send_item(mk_item(flc_pkg::ACT_LOAD, idx, pick_value(), 1'($urandom)));
        end
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 9) == 0)
            send_item(mk_item(flc_pkg::ACT_LOAD, flc_pkg::IDX_W'($urandom), pick_value(),
                              1'($urandom)));
          // Leave some streams unterminated so they run into the next one
          send_item(mk_item(flc_pkg::ACT_SAMPLE, flc_pkg::IDX_W'($urandom), pick_value(),
                            (j == len - 1) && ($urandom_range(0, 7) != 0)));
        end
      end
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = flc_pkg::TAP_CNT_RESET;
    err_count  = 0;
    items_sent = 0;
    beats_checked = 0;
    tap_writes = 0;
    flushes_seen = 0;
    tx_bursty  = 1'b0;
    rx_stalls  = 1'b0;
    burst_left = 0;
    tap_setting = flc_pkg::TAP_CNT_RESET;
    for (int k = 0; k < NUM_TAPS; k++) begin
      coef_mem[k]    = '0;
      sample_hist[k] = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_single_tap();
    tx_bursty = 1'b1;
    rx_stalls = 1'b1;
    test_full_kernel();
    test_tap_clamp();
    test_unused_coef();
    test_midstream_change();
    test_random_streams();
    write_taps(5'd1);
    send_item(mk_item(flc_pkg::ACT_SAMPLE, 4'd0, 16'sh7FFF, 1'b1));
    settle();

    if (pending_outputs.size() != 0)
      report_mismatch($sformatf("%0d predicted beats never arrived", pending_outputs.size()));

    $display("Sent %0d input beats over %0d tap count writes, %0d flushes.",
             items_sent, tap_writes, flushes_seen);
    $display("Checked %0d result beats, %0d mismatches.", beats_checked, err_count);
    if (err_count == 0) begin
      $display("full_linear_convolution_top_tb: clean");
    end else begin
      $display("full_linear_convolution_top_tb: errors");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #2000000;
    $display("Timed out with %0d beats still predicted.", pending_outputs.size());
    $display("full_linear_convolution_top_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/flc_pkg.sv
rtl/flc_cell.sv
rtl/flc_add_tree.sv
rtl/full_linear_convolution_top.sv
rtl/flc_checker.sv
dv/full_linear_convolution_top_tb.sv
